FILE: hw/rtl/ctab_pkg.sv
// Shared types, constants and the divide-by-255 helper for the tinted alpha blitter.
package ctab_pkg;

  localparam int MAX_DIM    = 1024;
  localparam int COORD_W    = 10;
  localparam int SUM_W      = COORD_W + 1;
  localparam int SIZE_W     = 11;
  localparam int PROD_W     = 2 * SIZE_W;
  localparam int IDX_W      = 20;
  localparam int CH_W       = 8;
  localparam int MUL_W      = 2 * CH_W;
  localparam int NUM_W      = 3 * CH_W;
  localparam int QUO_W      = 16;
  localparam int TINT_W     = 3 * CH_W;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;
  localparam logic [NUM_W-1:0] RND_OVER   = 24'd127;
  localparam logic [NUM_W-1:0] RND_TINT   = 24'd32512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X  = 3'd0,
    REG_OFFSET_Y  = 3'd1,
    REG_DEST_W    = 3'd2,
    REG_DEST_H    = 3'd3,
    REG_MODE      = 3'd4,
    REG_HAS_ALPHA = 3'd5,
    REG_TINT      = 3'd6,
    REG_NONE      = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_COPY = 2'd0,
    MODE_OVER = 2'd1,
    MODE_TINT = 2'd2,
    MODE_RSVD = 2'd3
  } blend_mode_t;

  typedef enum logic [1:0] {
    CLS_SKIP = 2'd0,
    CLS_COPY = 2'd1,
    CLS_OVER = 2'd2,
    CLS_TINT = 2'd3
  } pix_cls_t;

  typedef struct packed {
    logic [COORD_W-1:0] offset_x;
    logic [COORD_W-1:0] offset_y;
    logic [SIZE_W-1:0]  dest_width;
    logic [SIZE_W-1:0]  dest_height;
    blend_mode_t        mode;
    logic               has_alpha;
    logic [TINT_W-1:0]  tint;
  } cfg_t;

  typedef struct packed {
    pix_cls_t               cls;
    logic [SUM_W-1:0]       col;
    logic [SUM_W-1:0]       row;
    logic [SIZE_W-1:0]      w;
    logic [3:0][CH_W-1:0]   src;
    logic [2:0][CH_W-1:0]   dst;
  } pix_entry_t;

  // floor(x / 255): shift estimate, then one correction step
  function automatic logic [QUO_W-1:0] div255(input logic [NUM_W-1:0] x);
    logic [NUM_W:0]   s;
    logic [NUM_W:0]   r;
    logic [QUO_W-1:0] q;
    s = {1'b0, x} + (NUM_W+1)'(x >> 8) + (NUM_W+1)'(x >> 16);
    q = s[QUO_W+7:8];
    r = {1'b0, x} - ((NUM_W+1)'(q) << 8) + (NUM_W+1)'(q);
    if (r >= (NUM_W+1)'(CH_MAX)) begin
      q = q + QUO_W'(1);
    end
    return q;
  endfunction

endpackage

FILE: hw/rtl/clipped_tinted_alpha_blit_unit.sv
// Top level of the clipped, tinted alpha-over blitter stage.
//
// Input stream (in_): one word per source pixel with its coordinates, its
// RGBA and the current destination RGBA at the target. Output stream (out_):
// one word per input word, in order, carrying the destination address and
// the RGBA to store; out_tuser is the write enable.
// Configuration (cfg_): index/data writes, always ready, one register per
// write; change registers only while no pixel is in flight.
// Throughput is one pixel per clock while out_tready is high, set by the
// blend pipeline; the front register, products, numerator, divide and output
// register stages each hold one pixel, and the queue holds up to four.
// A 4-entry queue separates the classifying front end from the blend
// pipeline. When out_tready is low the pipeline stalls stage by stage, the
// queue fills, and in_tready drops once the queue and front register are full.
// Reset (rst_n low at a clock edge) empties the pipeline and queue and loads
// offsets 0, size 1024x1024, copy mode, has_alpha on, white tint.
module clipped_tinted_alpha_blit_unit
  import ctab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // src_col, src_row, src_red, src_green, src_blue, src_alpha,
  // dst_red, dst_green, dst_blue, dst_alpha, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // dest_index, out_red, out_green, out_blue, out_alpha
  output logic [OUT_DATA_W-1:0] out_tdata,
  // write_enable
  output logic                  out_tuser
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       q_push;
  pix_entry_t q_in;
  logic       q_full;
  logic       q_pop;
  pix_entry_t q_out;
  logic       q_empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X:  cfg_nxt.offset_x    = cfg_data[COORD_W-1:0];
        REG_OFFSET_Y:  cfg_nxt.offset_y    = cfg_data[COORD_W-1:0];
        REG_DEST_W:    cfg_nxt.dest_width  = cfg_data[SIZE_W-1:0];
        REG_DEST_H:    cfg_nxt.dest_height = cfg_data[SIZE_W-1:0];
        REG_MODE:      cfg_nxt.mode        = blend_mode_t'(cfg_data[1:0]);
        REG_HAS_ALPHA: cfg_nxt.has_alpha   = cfg_data[0];
        REG_TINT:      cfg_nxt.tint        = cfg_data[TINT_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_x    <= '0;
      cfg_r.offset_y    <= '0;
      cfg_r.dest_width  <= SIZE_W'(MAX_DIM);
      cfg_r.dest_height <= SIZE_W'(MAX_DIM);
      cfg_r.mode        <= MODE_COPY;
      cfg_r.has_alpha   <= 1'b1;
      cfg_r.tint        <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ctab_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  ctab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ctab_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .tint       (cfg_r.tint),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: hw/rtl/ctab_front.sv
// Front end: offset, clip and mode classification of incoming pixels.
module ctab_front
  import ctab_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  output logic                 q_push,
  output pix_entry_t           q_data,
  input  logic                 q_full
);

  logic             f_valid_r;
  logic             f_valid_nxt;
  pix_entry_t       f_entry_r;
  pix_entry_t       f_entry_nxt;
  logic [SUM_W-1:0] col;
  logic [SUM_W-1:0] row;
  logic [SIZE_W-1:0] w;
  logic [SIZE_W-1:0] h;
  logic             clipped;
  pix_cls_t         mode_cls;

  assign in_tready = !f_valid_r || !q_full;
  assign q_push    = f_valid_r && !q_full;
  assign q_data    = f_entry_r;

  always_comb begin
    col = SUM_W'(in_tdata[COORD_W-1:0]) + SUM_W'(cfg.offset_x);
    row = SUM_W'(in_tdata[2*COORD_W-1:COORD_W]) + SUM_W'(cfg.offset_y);
    w   = cfg.dest_width;
    h   = cfg.dest_height;
    if (MAX_DIM < 2**SIZE_W && cfg.dest_width > SIZE_W'(MAX_DIM)) begin
      w = SIZE_W'(MAX_DIM);
    end
    if (MAX_DIM < 2**SIZE_W && cfg.dest_height > SIZE_W'(MAX_DIM)) begin
      h = SIZE_W'(MAX_DIM);
    end
    clipped = (SIZE_W'(col) >= w) || (SIZE_W'(row) >= h);

    unique case (cfg.mode)
      MODE_TINT: mode_cls = cfg.has_alpha ? CLS_TINT : CLS_SKIP;
      MODE_OVER: mode_cls = cfg.has_alpha ? CLS_OVER : CLS_COPY;
      default:   mode_cls = CLS_COPY;
    endcase

    f_entry_nxt.cls = clipped ? CLS_SKIP : mode_cls;
    f_entry_nxt.col = col;
    f_entry_nxt.row = row;
    f_entry_nxt.w   = w;
    f_entry_nxt.src = in_tdata[2*COORD_W+4*CH_W-1:2*COORD_W];
    f_entry_nxt.dst = in_tdata[2*COORD_W+7*CH_W-1:2*COORD_W+4*CH_W];

    f_valid_nxt = f_valid_r;
    if (in_tready) begin
      f_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      f_entry_r <= f_entry_nxt;
    end
  end

endmodule

FILE: hw/rtl/ctab_queue.sv
// Short queue between front end and blend pipeline.
module ctab_queue
  import ctab_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pix_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output pix_entry_t pop_data,
  output logic       empty
);

  pix_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] wr_nxt;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W-1:0] rd_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + QCNT_W'(1))
    else $error("queue count missed a push");

  a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> rd_r == wr_r)
    else $error("queue empty with pointers apart");

endmodule

FILE: hw/rtl/ctab_back.sv
// Blend pipeline: address multiply, blend products, divide by 255, output register.
module ctab_back
  import ctab_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [TINT_W-1:0]     tint,
  input  logic                  q_empty,
  input  pix_entry_t            q_data,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  // stage 1: products
  logic                   v1_r;
  pix_cls_t               cls1_r;
  logic [SUM_W-1:0]       col1_r;
  logic [PROD_W-1:0]      rw1_r;
  logic [3:0][CH_W-1:0]   src1_r;
  logic [2:0][MUL_W-1:0]  st1_r;
  logic [2:0][MUL_W-1:0]  sa1_r;
  logic [2:0][MUL_W-1:0]  dd1_r;
  // stage 2: numerators
  logic                   v2_r;
  pix_cls_t               cls2_r;
  logic [IDX_W-1:0]       idx2_r;
  logic [3:0][CH_W-1:0]   src2_r;
  logic [2:0][NUM_W-1:0]  num2_r;
  // stage 3: first divide
  logic                   v3_r;
  pix_cls_t               cls3_r;
  logic [IDX_W-1:0]       idx3_r;
  logic [3:0][CH_W-1:0]   src3_r;
  logic [2:0][QUO_W-1:0]  q3_r;
  // stage 4: output register
  logic                   v4_r;
  logic [OUT_DATA_W-1:0]  data4_r;
  logic [OUT_DATA_W-1:0]  data4_nxt;
  logic                   we4_r;
  logic                   we4_nxt;

  logic                   adv1;
  logic                   adv2;
  logic                   adv3;
  logic                   adv4;
  logic [2:0][CH_W-1:0]   tint_ch;
  logic [2:0][MUL_W-1:0]  st_nxt;
  logic [2:0][MUL_W-1:0]  sa_nxt;
  logic [2:0][MUL_W-1:0]  dd_nxt;
  logic [2:0][NUM_W-1:0]  num_nxt;
  logic [2:0][NUM_W-1:0]  tprod;
  logic [2:0][NUM_W-1:0]  dd255;
  logic [2:0][QUO_W-1:0]  q_nxt;
  logic [2:0][QUO_W-1:0]  q2;
  logic [2:0][CH_W-1:0]   rgb4;
  logic [PROD_W-1:0]      idx_sum;
  logic [CH_W-1:0]        a1;
  logic [CH_W-1:0]        inv_a;

  assign adv4  = !v4_r || out_tready;
  assign adv3  = !v3_r || adv4;
  assign adv2  = !v2_r || adv3;
  assign adv1  = !v1_r || adv2;
  assign q_pop = adv1 && !q_empty;

  assign out_tvalid = v4_r;
  assign out_tdata  = data4_r;
  assign out_tuser  = we4_r;

  always_comb begin
    a1    = src1_r[3];
    inv_a = CH_MAX - q_data.src[3];
    for (int c = 0; c < 3; c++) begin
      tint_ch[c] = tint[(2-c)*CH_W +: CH_W];
      st_nxt[c]  = MUL_W'(q_data.src[c]) * MUL_W'(tint_ch[c]);
      sa_nxt[c]  = MUL_W'(q_data.src[c]) * MUL_W'(q_data.src[3]);
      dd_nxt[c]  = MUL_W'(q_data.dst[c]) * MUL_W'(inv_a);
      tprod[c]   = NUM_W'(st1_r[c]) * NUM_W'(a1);
      dd255[c]   = (NUM_W'(dd1_r[c]) << 8) - NUM_W'(dd1_r[c]);
      if (cls1_r == CLS_TINT) begin
        num_nxt[c] = tprod[c] + dd255[c] + RND_TINT;
      end else begin
        num_nxt[c] = NUM_W'(sa1_r[c]) + NUM_W'(dd1_r[c]) + RND_OVER;
      end
      q_nxt[c] = div255(num2_r[c]);
      q2[c]    = div255(NUM_W'(q3_r[c]));
      rgb4[c]  = (cls3_r == CLS_TINT) ? q2[c][CH_W-1:0] : q3_r[c][CH_W-1:0];
    end
    idx_sum = rw1_r + PROD_W'(col1_r);

    case (cls3_r) inside
      CLS_COPY: begin
        we4_nxt   = 1'b1;
        data4_nxt = OUT_DATA_W'({src3_r, idx3_r});
      end
      CLS_OVER, CLS_TINT: begin
        we4_nxt   = 1'b1;
        data4_nxt = OUT_DATA_W'({CH_MAX, rgb4, idx3_r});
      end
      default: begin
        we4_nxt   = 1'b0;
        data4_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= !q_empty;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cls1_r <= q_data.cls;
      col1_r <= q_data.col;
      rw1_r  <= PROD_W'(q_data.row) * PROD_W'(q_data.w);
      src1_r <= q_data.src;
      st1_r  <= st_nxt;
      sa1_r  <= sa_nxt;
      dd1_r  <= dd_nxt;
    end
    if (adv2 && v1_r) begin
      cls2_r <= cls1_r;
      idx2_r <= idx_sum[IDX_W-1:0];
      src2_r <= src1_r;
      num2_r <= num_nxt;
    end
    if (adv3 && v2_r) begin
      cls3_r <= cls2_r;
      idx3_r <= idx2_r;
      src3_r <= src2_r;
      q3_r   <= q_nxt;
    end
    if (adv4 && v3_r) begin
      data4_r <= data4_nxt;
      we4_r   <= we4_nxt;
    end
  end

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("dropped pixel carries nonzero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && v4_r && !out_tready |=> v3_r && v4_r)
    else $error("pipeline lost a word under stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed under stall");

endmodule
